### rtl/core/quadtree_bitmap_encoder_macros.svh
// ----------------------------------------------------------------------------
// quadtree_bitmap_encoder_macros.svh
// assertion helpers for the checker file of the quadtree encoder
// ----------------------------------------------------------------------------
`ifndef QUADTREE_BITMAP_ENCODER_MACROS_SVH
`define QUADTREE_BITMAP_ENCODER_MACROS_SVH

// same-cycle implication, held off during reset
`define QTBE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define QTBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/qtbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtbe_pkg
// shared constants and types of the quadtree bitmap encoder
// ----------------------------------------------------------------------------
package qtbe_pkg;

  // default deepest image side, as log2
  localparam int SIDE_LOG2_MAX_DEF = 6;
  // stored pixels per row
  localparam int ROW_BITS          = 64;
  // packed channel widths
  localparam int IN_TDATA_W        = 72;
  localparam int OUT_TDATA_W       = 8;
  localparam int CFG_W             = 3;
  localparam logic [CFG_W-1:0] SIDE_LOG2_RST = 3'd6;

  // command codes on in_tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // token codes, also the scan result codes for uniform and mixed blocks
  localparam logic [1:0] TOK_ZERO  = 2'd0;
  localparam logic [1:0] TOK_ONE   = 2'd1;
  localparam logic [1:0] TOK_OPEN  = 2'd2;
  localparam logic [1:0] TOK_CLOSE = 2'd3;
  localparam logic [1:0] KIND_MIXED = 2'd2;

  // quadrant counter value once all four children are finished
  localparam logic [2:0] QUAD_ALL_DONE = 3'd4;

  // result of the cursor for the pending request
  typedef struct packed {
    logic       need_scan;
    logic [1:0] tok;
    logic       last;
    logic       exhausted;
  } walk_res_t;

endpackage

### rtl/core/qtbe_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtbe_scan
// row store and uniformity scan: one row read and compared per cycle
// ----------------------------------------------------------------------------
module qtbe_scan
  import qtbe_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = SIDE_LOG2_MAX_DEF,
  localparam int ROW_COUNT    = 1 << MAX_SIDE_LOG2,
  localparam int LVL_W        = $clog2(MAX_SIDE_LOG2 + 1),
  localparam int CNT_W        = MAX_SIDE_LOG2 + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // row write
  input  logic                     wr_en,
  input  logic [MAX_SIDE_LOG2-1:0] wr_row,
  input  logic [ROW_BITS-1:0]      wr_data,
  // scan request
  input  logic                     start,
  input  logic [MAX_SIDE_LOG2-1:0] blk_row,
  input  logic [MAX_SIDE_LOG2-1:0] blk_col,
  input  logic [LVL_W-1:0]         blk_size_log2,
  // scan result
  output logic                     done,
  output logic [1:0]               kind
);

  logic [ROW_BITS-1:0]      mem [ROW_COUNT];
  logic [ROW_BITS-1:0]      rd_data_r;
  logic                     active_r;
  logic                     rd_valid_r;
  logic                     done_r;
  logic [CNT_W-1:0]         remaining_r;
  logic [MAX_SIDE_LOG2-1:0] row_ptr_r;
  logic [ROW_BITS-1:0]      mask_r;
  logic                     fits_r;
  logic                     all_zero_r;
  logic                     all_one_r;
  logic [CNT_W-1:0]         blk_size;
  logic [CNT_W-1:0]         col_end;
  logic [ROW_BITS-1:0]      mask_nxt;
  logic                     issue;
  logic [ROW_BITS-1:0]      seg;

  // column window of the block, clipped to the stored row
  assign blk_size = CNT_W'(1) << blk_size_log2;
  assign col_end  = {1'b0, blk_col} + blk_size;
  assign mask_nxt = (~{ROW_BITS{1'b0}} << blk_col) & ~(~{ROW_BITS{1'b0}} << col_end);

  assign issue = active_r && (remaining_r != '0);
  assign seg   = rd_data_r & mask_r;

  // row store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // row store read port, registered
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[row_ptr_r];
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      rd_valid_r  <= 1'b0;
      done_r      <= 1'b0;
      remaining_r <= '0;
    end else begin
      rd_valid_r <= issue;
      done_r     <= 1'b0;
      if (start) begin
        active_r    <= 1'b1;
        remaining_r <= blk_size;
      end else if (issue) begin
        remaining_r <= remaining_r - CNT_W'(1);
      end else if (active_r && !rd_valid_r) begin
        active_r <= 1'b0;
        done_r   <= 1'b1;
      end
    end
  end

  // block position, window and running uniformity flags
  always_ff @(posedge clk) begin
    if (start) begin
      row_ptr_r  <= blk_row;
      mask_r     <= mask_nxt;
      fits_r     <= (32'(col_end) <= ROW_BITS);
      all_zero_r <= 1'b1;
      all_one_r  <= 1'b1;
    end else begin
      if (issue) begin
        row_ptr_r <= row_ptr_r + MAX_SIDE_LOG2'(1);
      end
      if (rd_valid_r) begin
        all_zero_r <= all_zero_r && (seg == '0);
        all_one_r  <= all_one_r && (seg == mask_r) && fits_r;
      end
    end
  end

  assign done = done_r;
  assign kind = all_zero_r ? TOK_ZERO : (all_one_r ? TOK_ONE : KIND_MIXED);

endmodule

### rtl/core/qtbe_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtbe_walk
// depth-first cursor over the quadtree: quadrant path, level and end flag
// ----------------------------------------------------------------------------
module qtbe_walk
  import qtbe_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = SIDE_LOG2_MAX_DEF,
  localparam int LVL_W        = $clog2(MAX_SIDE_LOG2 + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [LVL_W-1:0]         side_log2,
  input  logic                     restart,
  input  logic                     commit,
  input  logic [1:0]               kind,
  output walk_res_t                res,
  output logic [MAX_SIDE_LOG2-1:0] blk_row,
  output logic [MAX_SIDE_LOG2-1:0] blk_col,
  output logic [LVL_W-1:0]         blk_size_log2
);

  logic [2:0]       path_r   [0:MAX_SIDE_LOG2];
  logic [2:0]       path_nxt [0:MAX_SIDE_LOG2];
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [LVL_W-1:0] lvl_c;
  logic [LVL_W-1:0] lvl_up;
  logic [LVL_W-1:0] lvl_dn;
  logic             close_pend;

  // cursor level clipped to the image depth
  assign lvl_c      = (level_r > side_log2) ? side_log2 : level_r;
  assign lvl_up     = lvl_c + LVL_W'(1);
  assign lvl_dn     = level_r - LVL_W'(1);
  assign close_pend = (level_r != '0) && (path_r[level_r] >= QUAD_ALL_DONE);
  assign blk_size_log2 = side_log2 - lvl_c;

  // block origin from the quadrant path
  always_comb begin
    blk_row = '0;
    blk_col = '0;
    for (int lv = 1; lv <= MAX_SIDE_LOG2; lv++) begin
      if (LVL_W'(lv) <= lvl_c) begin
        blk_row = blk_row | (MAX_SIDE_LOG2'(path_r[lv][1]) << (int'(side_log2) - lv));
        blk_col = blk_col | (MAX_SIDE_LOG2'(path_r[lv][0]) << (int'(side_log2) - lv));
      end
    end
  end

  // token for the pending request
  always_comb begin
    res.need_scan = !done_r && !close_pend;
    res.exhausted = 1'b0;
    res.last      = 1'b0;
    res.tok       = TOK_ZERO;
    if (done_r) begin
      res.exhausted = 1'b1;
    end else if (close_pend) begin
      res.tok  = TOK_CLOSE;
      res.last = (level_r == LVL_W'(1));
    end else if (kind != KIND_MIXED) begin
      res.tok  = kind;
      res.last = (lvl_c == '0);
    end else begin
      res.tok  = TOK_OPEN;
    end
  end

  // cursor step
  always_comb begin
    path_nxt  = path_r;
    level_nxt = level_r;
    done_nxt  = done_r;
    if (restart) begin
      for (int i = 0; i <= MAX_SIDE_LOG2; i++) begin
        path_nxt[i] = '0;
      end
      level_nxt = '0;
      done_nxt  = 1'b0;
    end else if (commit && !done_r) begin
      if (close_pend) begin
        path_nxt[level_r] = '0;
        level_nxt         = lvl_dn;
        if (lvl_dn == '0) begin
          done_nxt = 1'b1;
        end else begin
          path_nxt[lvl_dn] = path_r[lvl_dn] + 3'd1;
        end
      end else if (kind != KIND_MIXED) begin
        level_nxt = lvl_c;
        if (lvl_c == '0) begin
          done_nxt = 1'b1;
        end else begin
          path_nxt[lvl_c] = path_r[lvl_c] + 3'd1;
        end
      end else begin
        level_nxt        = lvl_up;
        path_nxt[lvl_up] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_SIDE_LOG2; i++) begin
        path_r[i] <= '0;
      end
      level_r <= '0;
      done_r  <= 1'b0;
    end else begin
      path_r  <= path_nxt;
      level_r <= level_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

### rtl/core/quadtree_bitmap_encoder.sv
`timescale 1ns / 1ps
// A load transaction writes one image row and restarts the encoding. A
// token request that needs a uniformity check scans the rows of the current
// block, of side 2^(k - level), k being the image side log2 and level the
// depth of the current block, so up to 2^MAX_SIDE_LOG2 rows for the whole
// image; the row store has one read port and the scan reads one row per
// cycle. Close brackets and requests after the end need no scan. The input
// is not ready while a request is in work or while its result waits for the
// output register to be freed.
// ----------------------------------------------------------------------------
// quadtree_bitmap_encoder
// streaming quadtree encoder for a square binary image, one token per request
// ----------------------------------------------------------------------------
module quadtree_bitmap_encoder
  import qtbe_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = SIDE_LOG2_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row_index[5:0], row_bits[69:6], zero pad
  input  logic                   in_tuser,   // cmd
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // token[1:0], zero pad
  output logic                   out_tlast,  // last
  output logic                   out_tuser,  // exhausted
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data // image_side_log2
);

  localparam int LVL_W = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int ROW_COUNT = 1 << MAX_SIDE_LOG2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                   state_r;
  state_t                   state_nxt;
  logic [CFG_W-1:0]         side_log2_r;
  logic                     out_tvalid_r;
  logic [1:0]               out_tok_r;
  logic                     out_last_r;
  logic                     out_exh_r;
  logic [LVL_W-1:0]         side_c;
  logic                     in_acc;
  logic                     load_acc;
  logic                     req_acc;
  logic                     out_free;
  logic                     commit;
  logic                     scan_start;
  logic                     scan_done;
  logic [1:0]               scan_kind;
  logic                     row_ok;
  walk_res_t                walk_res;
  logic [MAX_SIDE_LOG2-1:0] blk_row;
  logic [MAX_SIDE_LOG2-1:0] blk_col;
  logic [LVL_W-1:0]         blk_size_log2;

  // handshake decode
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign load_acc   = in_acc && (in_tuser == CMD_LOAD);
  assign req_acc    = in_acc && (in_tuser == CMD_REQUEST);
  assign out_free   = !out_tvalid_r || out_tready;
  assign commit     = (state_r == S_OUT) && out_free;
  assign scan_start = req_acc && walk_res.need_scan;
  assign row_ok     = (32'(in_tdata[5:0]) < ROW_COUNT);

  // image side saturated to the deepest supported level
  assign side_c = (32'(side_log2_r) > MAX_SIDE_LOG2) ? LVL_W'(MAX_SIDE_LOG2)
                                                     : LVL_W'(side_log2_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= SIDE_LOG2_RST;
    end else if (cfg_wr_en) begin
      side_log2_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_acc) begin
          state_nxt = walk_res.need_scan ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_tok_r  <= walk_res.tok;
      out_last_r <= walk_res.last;
      out_exh_r  <= walk_res.exhausted;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_tok_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_exh_r;

  // quadtree cursor
  qtbe_walk #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .side_log2     (side_c),
    .restart       (load_acc || cfg_wr_en),
    .commit        (commit),
    .kind          (scan_kind),
    .res           (walk_res),
    .blk_row       (blk_row),
    .blk_col       (blk_col),
    .blk_size_log2 (blk_size_log2)
  );

  // row store and block scan
  qtbe_scan #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (load_acc && row_ok),
    .wr_row        (MAX_SIDE_LOG2'(in_tdata[5:0])),
    .wr_data       (in_tdata[69:6]),
    .start         (scan_start),
    .blk_row       (blk_row),
    .blk_col       (blk_col),
    .blk_size_log2 (blk_size_log2),
    .done          (scan_done),
    .kind          (scan_kind)
  );

endmodule

### rtl/core/qtbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtbe_checker
// port-level checks of the quadtree encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "quadtree_bitmap_encoder_macros.svh"

module qtbe_checker
  import qtbe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser,
  input logic                   cfg_wr_en,
  input logic [CFG_W-1:0]       cfg_wr_data
);

  // an exhausted report carries a zero token and never ends the encoding
  `QTBE_ASSERT_IMPL(a_exh_clean, clk, rst_n, out_tvalid && out_tuser, out_tdata[1:0] == TOK_ZERO && !out_tlast, "exhausted result with token or last set")

  // a stalled result transaction holds its contents
  `QTBE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // a row load never produces a result
  `QTBE_ASSERT_NEXT(a_load_silent, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_LOAD && !out_tvalid, !out_tvalid, "result appeared after a row load")

  // a request occupies the block for at least the next cycle
  `QTBE_ASSERT_NEXT(a_req_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_REQUEST, !in_tready, "input ready right after a request")

endmodule

bind quadtree_bitmap_encoder qtbe_checker u_qtbe_checker (.*);
